### rtl/uwbff_pkg.sv
// Package for the receive frame filter: frame layout constants, status
// codes, configuration register indexes and the result item type.
// No dependencies.
package uwbff_pkg;

  // Frame control bytes of a short-address data frame
  localparam logic [7:0] FC_BYTE0 = 8'h41;
  localparam logic [7:0] FC_BYTE1 = 8'h88;

  // Header and checksum sizes in bytes
  localparam logic [7:0] HEADER_LEN    = 8'd9;
  localparam logic [7:0] CHECKSUM_LEN  = 8'd2;
  localparam logic [7:0] MIN_FRAME_LEN = HEADER_LEN + CHECKSUM_LEN;

  // Byte positions inside the header
  localparam logic [7:0] POS_FC0     = 8'd0;
  localparam logic [7:0] POS_FC1     = 8'd1;
  localparam logic [7:0] POS_PAN_LO  = 8'd3;
  localparam logic [7:0] POS_PAN_HI  = 8'd4;
  localparam logic [7:0] POS_DST_LO  = 8'd5;
  localparam logic [7:0] POS_DST_HI  = 8'd6;
  localparam logic [7:0] POS_SRC_LO  = 8'd7;
  localparam logic [7:0] POS_SRC_HI  = 8'd8;

  // Broadcast-style destination accepted besides the own address
  localparam logic [15:0] DEST_ZERO = 16'h0000;

  // Frame status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ADDR_ERR   = 2'd1,
    ST_MEM_ERR    = 2'd2,
    ST_TIMEOUT    = 2'd3
  } status_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PAN_ID      = 2'd0,
    CFG_SHORT_ADDR  = 2'd1,
    CFG_MAX_PAYLOAD = 2'd2
  } cfg_reg_e;

  // One result item
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_done;
    status_e     status;
    logic [15:0] sender_address;
    logic [7:0]  payload_length;
  } result_t;

endpackage

### rtl/uwb_rx_frame_filter.sv
// Receive frame filter top level: header checks, payload holdback and
// end-of-frame status, with an output register and skid stage.
// Depends on uwbff_pkg.
// Throughput: one byte per cycle while the skid stage is empty; the per-byte check
// is a single compare and counter update, and the two-entry output stage keeps input
// open while one result waits.
// Reset: asynchronous, active low; clears frame state and loads register defaults
// (PAN ID 0xABCD, short address 0x0001, payload limit 116).
module uwb_rx_frame_filter
  import uwbff_pkg::*;
#(
  parameter int MAX_FRAME_LEN = 127
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input byte channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        last_byte_i,
  input  logic        rx_error_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        payload_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic        frame_done_o,
  output logic [1:0]  status_o,
  output logic [15:0] sender_address_o,
  output logic [7:0]  payload_length_o
);

  localparam logic [8:0] MaxLen = 9'(MAX_FRAME_LEN);

  // configuration registers
  logic [15:0] pan_id_q;
  logic [15:0] short_addr_q;
  logic [7:0]  max_payload_q;

  // frame state
  logic [7:0]  byte_index_q, byte_index_d;
  logic        addr_fault_q, addr_fault_d;
  logic        dest_own_q, dest_own_d;
  logic        dest_zero_q, dest_zero_d;
  logic [15:0] sender_q, sender_d;
  logic [7:0]  hold0_q, hold1_q;

  // output stage
  logic        out_vld_q, skid_vld_q;
  result_t     out_q, skid_q;

  logic        in_acc;
  logic        pop;
  logic        push;
  logic        addr_ok;
  logic        pv;
  logic [7:0]  pay_pos;
  logic [7:0]  plen;
  result_t     res;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~skid_vld_q;
  assign in_acc      = in_valid_i & in_ready_o;
  assign pop         = out_vld_q & out_ready_i;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_id_q      <= 16'hABCD;
      short_addr_q  <= 16'h0001;
      max_payload_q <= 8'd116;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_PAN_ID:      pan_id_q      <= cfg_data_i;
        CFG_SHORT_ADDR:  short_addr_q  <= cfg_data_i;
        CFG_MAX_PAYLOAD: max_payload_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // check header bytes against frame control, own PAN ID and address, capture sender
  always_comb begin
    addr_fault_d = addr_fault_q;
    dest_own_d   = dest_own_q;
    dest_zero_d  = dest_zero_q;
    sender_d     = sender_q;
    case (byte_index_q)
      POS_FC0:    if (rx_byte_i != FC_BYTE0) addr_fault_d = 1'b1;
      POS_FC1:    if (rx_byte_i != FC_BYTE1) addr_fault_d = 1'b1;
      POS_PAN_LO: if (rx_byte_i != pan_id_q[7:0]) addr_fault_d = 1'b1;
      POS_PAN_HI: if (rx_byte_i != pan_id_q[15:8]) addr_fault_d = 1'b1;
      POS_DST_LO: begin
        if (rx_byte_i != short_addr_q[7:0]) dest_own_d = 1'b0;
        if (rx_byte_i != DEST_ZERO[7:0]) dest_zero_d = 1'b0;
      end
      POS_DST_HI: begin
        if (rx_byte_i != short_addr_q[15:8]) dest_own_d = 1'b0;
        if (rx_byte_i != DEST_ZERO[15:8]) dest_zero_d = 1'b0;
      end
      POS_SRC_LO: sender_d = {sender_q[15:8], rx_byte_i};
      POS_SRC_HI: sender_d = {rx_byte_i, sender_q[7:0]};
      default: ;
    endcase
  end

  // release gating and end-of-frame status
  always_comb begin
    addr_ok = ~addr_fault_d & (dest_own_d | dest_zero_d);
    pay_pos = byte_index_q - MIN_FRAME_LEN;
    plen    = byte_index_q - (MIN_FRAME_LEN - 8'd1);
    pv = (byte_index_q >= MIN_FRAME_LEN) && ({1'b0, byte_index_q} < MaxLen) &&
         addr_ok && (pay_pos < max_payload_q);

    res                = '0;
    res.status         = ST_OK;
    res.payload_valid  = pv;
    res.payload_byte   = pv ? hold0_q : 8'd0;
    res.frame_done     = last_byte_i;
    if (last_byte_i) begin
      if (({1'b0, byte_index_q} >= MaxLen) || (byte_index_q < MIN_FRAME_LEN - 8'd1)) begin
        res.status = ST_MEM_ERR;
      end else if (!addr_ok) begin
        res.status = ST_ADDR_ERR;
      end else if (plen > max_payload_q) begin
        res.status = ST_MEM_ERR;
      end else begin
        res.status         = ST_OK;
        res.payload_length = plen;
        res.sender_address = sender_d;
      end
    end
    if (rx_error_i) begin
      res            = '0;
      res.frame_done = 1'b1;
      res.status     = ST_TIMEOUT;
    end
    push = in_acc & (rx_error_i | last_byte_i | pv);
  end

  // advance byte position, saturating
  assign byte_index_d = (byte_index_q == 8'hFF) ? byte_index_q : byte_index_q + 8'd1;

  // update frame state; restore defaults at every end of frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      addr_fault_q <= 1'b0;
      dest_own_q   <= 1'b1;
      dest_zero_q  <= 1'b1;
      sender_q     <= '0;
    end else if (in_acc) begin
      if (rx_error_i || last_byte_i) begin
        byte_index_q <= '0;
        addr_fault_q <= 1'b0;
        dest_own_q   <= 1'b1;
        dest_zero_q  <= 1'b1;
        sender_q     <= '0;
      end else begin
        byte_index_q <= byte_index_d;
        addr_fault_q <= addr_fault_d;
        dest_own_q   <= dest_own_d;
        dest_zero_q  <= dest_zero_d;
        sender_q     <= sender_d;
      end
    end
  end

  // shift the two-byte holdback line
  always_ff @(posedge clk_i) begin
    if (in_acc && !rx_error_i) begin
      hold0_q <= hold1_q;
      hold1_q <= rx_byte_i;
    end
  end

  // output register and skid stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= push;
      end else begin
        out_vld_q  <= push;
      end
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  // output register and skid stage data
  always_ff @(posedge clk_i) begin
    if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_q  <= skid_q;
        skid_q <= res;
      end else begin
        out_q  <= res;
      end
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign payload_valid_o  = out_q.payload_valid;
  assign payload_byte_o   = out_q.payload_byte;
  assign frame_done_o     = out_q.frame_done;
  assign status_o         = out_q.status;
  assign sender_address_o = out_q.sender_address;
  assign payload_length_o = out_q.payload_length;

  // skid stage only fills behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid stage holds an item while output register is empty");

  // a failed frame reports no length and no sender
  a_fail_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o && status_o != ST_OK) |->
    (payload_length_o == 8'd0 && sender_address_o == 16'd0))
    else $error("failed frame carries length or sender");

  // a receiver error restarts the frame at position zero
  a_err_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && rx_error_i) |=> (byte_index_q == 8'd0 && !addr_fault_q))
    else $error("frame state not restored after receiver error");

  // a timeout result never releases a payload byte
  a_timeout_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_TIMEOUT) |-> !payload_valid_o)
    else $error("timeout result carries a payload byte");

endmodule
